// ----- rtl/sbda_pkg.sv -----
// Shared types and character constants for the signed binary to decimal text block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbda_pkg;

    localparam int FIELD_BITS = 64;
    localparam int DIGIT_W    = 4;

    typedef logic signed [FIELD_BITS-1:0] t_value;
    typedef logic        [7:0]            t_char;
    typedef logic        [DIGIT_W-1:0]    t_digit;

    localparam t_char  CH_ZERO  = 8'd48;
    localparam t_char  CH_MINUS = 8'd45;
    localparam t_digit BCD_FIVE = 4'd5;
    localparam t_digit BCD_ADJ  = 4'd3;

endpackage

`default_nettype wire

// ----- rtl/sbda_in_if.sv -----
// Input channel: one signed integer word per handshake.
// Depends on sbda_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sbda_in_if import sbda_pkg::*;;
    logic   valid;
    logic   ready;
    t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/sbda_out_if.sv -----
// Output channel: one ASCII character word per handshake, with a last flag.
// Depends on sbda_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sbda_out_if import sbda_pkg::*;;
    logic  valid;
    logic  ready;
    t_char char_out;
    logic  last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/signed_binary_to_decimal_ascii_top.sv -----
// Top level of the signed binary to decimal ASCII converter.
// Depends on sbda_pkg, sbda_in_if and sbda_out_if.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Word                         Accepted when
// -------  ---  ---------------------------  ------------------------
// i_in     in   value (64b signed)           i_in.valid & i_in.ready
// o_out    out  char_out (8b ASCII), last    o_out.valid & o_out.ready
//
// Sequence: the idle state takes the word, then bit-serial double dabble
// (one magnitude bit shifted into the BCD register per cycle), then leading zero
// digits are dropped one per cycle, then one character goes out per cycle while
// the sink is ready. Dropped and emitted digits always add up to NDIG; a minus
// sign adds one more character. Reset (synchronous, active low) returns the
// sequencer to idle; the BCD and magnitude registers are overwritten on every
// load. A stalled sink holds the current character; input is taken only while
// idle.

module signed_binary_to_decimal_ascii_top import sbda_pkg::*; #(
    parameter int VALUE_BITS = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sbda_in_if.sink    i_in,
    sbda_out_if.source o_out
);

    // decimal digits needed for VALUE_BITS-bit magnitudes (floor(n*log10 2)+1)
    localparam int NDIG  = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W = NDIG * DIGIT_W;
    localparam int BIT_W = $clog2(VALUE_BITS + 1);
    localparam int CNT_W = $clog2(NDIG + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SKIP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]            r_state, n_state;
    logic                  r_neg, n_neg;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    logic [VALUE_BITS-1:0] w_raw;
    logic [BCD_W-1:0]      w_adj;
    t_digit                w_top;

    assign w_raw = i_in.value[VALUE_BITS-1:0];
    assign w_top = r_bcd[BCD_W-1 -: DIGIT_W];

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*DIGIT_W +: DIGIT_W] >= BCD_FIVE) begin
                w_adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W] + BCD_ADJ;
            end else begin
                w_adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = (r_state == S_EMIT);
    assign o_out.char_out = r_neg ? CH_MINUS : (CH_ZERO + {4'd0, w_top});
    assign o_out.last     = !r_neg && (r_cnt == CNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_bcd   = r_bcd;
        n_bit   = r_bit;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    // load magnitude; the most negative value negates to itself unsigned
                    n_neg   = w_raw[VALUE_BITS-1];
                    n_mag   = w_raw[VALUE_BITS-1] ? (~w_raw + VALUE_BITS'(1)) : w_raw;
                    n_bcd   = '0;
                    n_bit   = BIT_W'(VALUE_BITS);
                    n_cnt   = CNT_W'(NDIG);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[BCD_W-2:0], r_mag[VALUE_BITS-1]};
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_bit = r_bit - BIT_W'(1);
                if (r_bit == BIT_W'(1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zero digits, keep at least one
                if (w_top == '0 && r_cnt != CNT_W'(1)) begin
                    n_bcd = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_cnt = r_cnt - CNT_W'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_out.ready) begin
                    if (r_neg) begin
                        n_neg = 1'b0;
                    end else begin
                        n_bcd = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        n_cnt = r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
        end
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_bit <= n_bit;
        r_cnt <= n_cnt;
    end

endmodule

`default_nettype wire
